>>> hdl/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// Command and status codes shared by the positional insert/delete array.
// ----------------------------------------------------------------------------
package pia_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int FILL_W   = 7;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 48;  // 42 payload bits rounded up to bytes
    localparam int M_TDATA_W = 48;  // 41 payload bits rounded up to bytes

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

endpackage

>>> hdl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array of signed words with clear, append, insert, delete and read.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH signed 32-bit words in order, with a fill count.
// Each input transfer carries one command and gives exactly one result
// transfer with the deleted or read word, the count after the command and a
// status. One command is taken every clock cycle while the result path is
// not stalled by m_tready; the command waits in the input register, then the
// whole array updates, every entry loading from itself, a neighbor or the new
// word, while the result register is loaded. Positions are 1-based.
module positional_insert_delete_array #(
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] cmd, [9:3] position, [41:10] value, [47:42] zero
    input  logic [pia_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] data, [38:32] fill_count, [40:39] status, [47:41] zero
    output logic [pia_pkg::M_TDATA_W-1:0] m_tdata
);
    import pia_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Input register.
    logic                     in_valid_reg;
    logic [CMD_W-1:0]         in_cmd_reg;
    logic [POS_W-1:0]         in_pos_reg;
    logic signed [WORD_W-1:0] in_value_reg;

    // Result register.
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_data_reg;
    logic [FILL_W-1:0]        out_fill_reg;
    status_t                  out_status_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [WORD_W-1:0]        elem_reg  [DEPTH];
    logic [WORD_W-1:0]        elem_next [DEPTH];

    logic                     exec;
    logic                     full;
    logic                     empty;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         idx_ext;
    logic [IDX_W-1:0]         idx;
    logic                     pos_ok_ins;
    logic                     pos_ok_rd;
    logic                     do_append;
    logic                     do_insert;
    logic                     do_delete;
    logic signed [WORD_W-1:0] data_next;
    status_t                  status_next;

    // The command in the input register executes when the result register
    // is free or is being emptied in this cycle.
    assign exec     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;

    assign full    = (count_reg >= CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(in_pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_ext = pos_ext - CMP_W'(1);
    assign idx     = idx_ext[IDX_W-1:0];

    assign pos_ok_ins = (in_pos_reg != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign pos_ok_rd  = (in_pos_reg != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        do_append   = 1'b0;
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        data_next   = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (cmd_t'(in_cmd_reg))
            CMD_CLEAR: begin
                count_next = '0;
            end
            CMD_APPEND: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_append  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (!pos_ok_ins) begin
                    status_next = ST_BADPOS;
                end else begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!pos_ok_rd) begin
                    status_next = ST_BADPOS;
                end else begin
                    do_delete  = 1'b1;
                    data_next  = elem_reg[idx];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!pos_ok_rd) begin
                    status_next = ST_BADPOS;
                end else begin
                    data_next = elem_reg[idx];
                end
            end
            default: begin
            end
        endcase
    end

    // Each entry loads from itself, its lower or upper neighbor, or the new
    // word. Entries at or above the count are don't-care, so shifts may move
    // stale words freely there.
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [WORD_W-1:0] below;
            logic [WORD_W-1:0] above;
            if (k == 0) begin : g_first
                assign below = elem_reg[k];
            end else begin : g_lower
                assign below = elem_reg[k-1];
            end
            if (k == DEPTH - 1) begin : g_last
                assign above = elem_reg[k];
            end else begin : g_upper
                assign above = elem_reg[k+1];
            end

            always_comb begin
                priority if (do_append && (cnt_ext == CMP_W'(k))) begin
                    elem_next[k] = in_value_reg;
                end else if (do_insert && (idx_ext == CMP_W'(k))) begin
                    elem_next[k] = in_value_reg;
                end else if (do_insert && (CMP_W'(k) > idx_ext)) begin
                    elem_next[k] = below;
                end else if (do_delete && (CMP_W'(k) >= idx_ext)) begin
                    elem_next[k] = above;
                end else begin
                    elem_next[k] = elem_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (exec) begin
                    elem_reg[k] <= elem_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (exec) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tdata[CMD_W-1:0];
            in_pos_reg   <= s_tdata[CMD_W+POS_W-1:CMD_W];
            in_value_reg <= s_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];
        end
        if (exec) begin
            out_data_reg   <= data_next;
            out_fill_reg   <= FILL_W'(count_next);
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - FILL_W - STATUS_W){1'b0}},
                       out_status_reg, out_fill_reg, out_data_reg};

endmodule
